@@ hdl/kest_pkg.sv @@
// ----------------------------------------------------------------------------
// kest_pkg
// shared types, codes and constants for the keyed expiring slot table
// ----------------------------------------------------------------------------
`default_nettype none
package kest_pkg;

  localparam int SlotCountDefault = 32;
  localparam logic [15:0] LifetimeReset = 16'd200;
  localparam int InDataW = 160;
  localparam int OutDataW = 136;
  localparam int QueueDepth = 2;

  typedef enum logic [2:0] {
    ST_MATCH = 3'd0,
    ST_ALLOC = 3'd1,
    ST_OVERFLOW = 3'd2,
    ST_RAIL = 3'd3,
    ST_LIVE = 3'd4,
    ST_DEAD = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_READ = 2'd1,
    CMD_RAIL = 2'd2
  } cmd_kind_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_MATCH_SCAN,
    BK_FREE_SCAN,
    BK_READ,
    BK_OUT
  } back_state_t;

  localparam logic [0:0] REG_LIFETIME = 1'b0;

  // command handed from the front part to the back part
  typedef struct packed {
    cmd_kind_t cmd;
    logic [1:0] kind2;
    logic [15:0] key;
    logic [95:0] coords;
    logic [31:0] now_ms;
    logic [4:0] read_slot;
    logic [7:0] rail_color;
  } cmd_t;

  typedef struct packed {
    status_t status;
    logic [4:0] slot_index;
    logic [7:0] rail_color;
    logic [15:0] entity;
    logic [2:0] kind;
    logic [95:0] coords;
  } result_t;

  function automatic logic [7:0] rail_palette(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0: c = 8'd6;
      3'd1: c = 8'd208;
      3'd2: c = 8'd180;
      3'd3: c = 8'd35;
      3'd4: c = 8'd224;
      3'd5: c = 8'd133;
      3'd6: c = 8'd192;
      default: c = 8'd6;
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

@@ hdl/kest_front.sv @@
// ----------------------------------------------------------------------------
// kest_front
// accepts input transactions, classifies them and pushes commands to a queue
// ----------------------------------------------------------------------------
`default_nettype none
module kest_front (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic in_ready,
  input  wire logic [kest_pkg::InDataW-1:0] in_data,
  output kest_pkg::cmd_t q_data,
  output logic q_valid,
  input  wire logic q_pop
);
  import kest_pkg::*;

  localparam int PtrW = $clog2(QueueDepth);

  cmd_t q_mem [QueueDepth];
  logic [PtrW-1:0] wr_ptr, rd_ptr;
  logic [PtrW:0] count;
  cmd_t cmd;
  logic push;
  logic [2:0] kind;
  logic [15:0] key;

  assign in_ready = (count != (PtrW+1)'(QueueDepth));
  assign push = in_valid && in_ready;
  assign q_valid = (count != '0);
  assign q_data = q_mem[rd_ptr];

  always_comb begin
    kind = in_data[3:1];
    key = in_data[19:4];
    cmd.kind2 = (kind >= 3'd1 && kind <= 3'd3) ? 2'(kind - 3'd1) : 2'd3;
    cmd.key = key;
    cmd.coords = in_data[115:20];
    cmd.now_ms = in_data[147:116];
    cmd.read_slot = in_data[152:148];
    cmd.rail_color = rail_palette(key[2:0]);
    if (in_data[0]) begin
      cmd.cmd = CMD_READ;
    end else if (kind == 3'd1 && key[15] && key[15:9] == 7'h7f) begin
      // keys -512..-1
      cmd.cmd = CMD_RAIL;
    end else begin
      cmd.cmd = CMD_INSERT;
    end
  end

  always_ff @(posedge clk) begin
    if (push) q_mem[wr_ptr] <= cmd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PtrW'(QueueDepth-1)) ? '0 : wr_ptr + 1'b1;
      if (q_pop) rd_ptr <= (rd_ptr == PtrW'(QueueDepth-1)) ? '0 : rd_ptr + 1'b1;
      count <= count + (PtrW+1)'(push) - (PtrW+1)'(q_pop);
    end
  end
endmodule
`default_nettype wire

@@ hdl/kest_back.sv @@
// ----------------------------------------------------------------------------
// kest_back
// walks the slot table for inserts and reads and delivers one result per command
// ----------------------------------------------------------------------------
`default_nettype none
module kest_back #(
  parameter int SLOT_COUNT = kest_pkg::SlotCountDefault
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic [15:0] lifetime_ms,
  input  kest_pkg::cmd_t q_data,
  input  wire logic q_valid,
  output logic q_pop,
  output kest_pkg::result_t res,
  output logic res_valid,
  input  wire logic res_ready
);
  import kest_pkg::*;

  localparam int IdxW = $clog2(SLOT_COUNT);
  localparam int CntW = IdxW + 1;

  back_state_t state, state_next;
  logic [SLOT_COUNT-1:0] slot_used;
  logic [15:0] slot_key [SLOT_COUNT];
  logic [1:0] slot_kind [SLOT_COUNT];
  logic [31:0] slot_end [SLOT_COUNT];
  logic [95:0] slot_coords [SLOT_COUNT];

  logic [CntW-1:0] scan;
  logic [IdxW-1:0] sidx;
  logic [15:0] rd_key;
  logic [1:0] rd_kind;
  logic [31:0] rd_end;
  logic [95:0] rd_coords;
  logic rd_used, do_write, last;
  logic [IdxW-1:0] widx;
  result_t res_next;
  cmd_t cur;

  assign sidx = scan[IdxW-1:0];
  assign last = (scan == CntW'(SLOT_COUNT-1));

  // registered reads; valid bits make never-written entries read zero
  always_ff @(posedge clk) begin
    rd_key <= slot_key[sidx];
    rd_kind <= slot_kind[sidx];
    rd_end <= slot_end[sidx];
    rd_coords <= slot_coords[sidx];
  end
  logic [SLOT_COUNT-1:0] written;
  logic rd_written;
  logic [15:0] key_v;
  logic [1:0] kind_v;
  logic [31:0] end_v;
  logic [95:0] coords_v;
  always_ff @(posedge clk) begin
    rd_used <= slot_used[sidx];
    rd_written <= written[sidx];
  end
  assign key_v = rd_written ? rd_key : '0;
  assign kind_v = rd_written ? rd_kind : '0;
  assign end_v = rd_written ? rd_end : '0;
  assign coords_v = rd_written ? rd_coords : '0;

  // scan pipeline: the read data registers and chk hold the same slot, so data and index are compared together
  logic [CntW-1:0] chk;
  logic chk_v;
  logic [IdxW-1:0] cidx;
  logic [31:0] cdiff;
  assign cidx = chk[IdxW-1:0];
  assign cdiff = end_v - cur.now_ms;

  always_comb begin
    state_next = state;
    q_pop = 1'b0;
    do_write = 1'b0;
    widx = cidx;
    res_next = res;
    unique case (state)
      BK_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          unique case (q_data.cmd)
            CMD_READ: state_next = BK_READ;
            CMD_RAIL: begin
              res_next = '0;
              res_next.status = ST_RAIL;
              res_next.rail_color = q_data.rail_color;
              state_next = BK_OUT;
            end
            default: state_next = BK_MATCH_SCAN;
          endcase
        end
      end
      BK_MATCH_SCAN: begin
        if (chk_v && key_v == cur.key) begin
          do_write = 1'b1;
          res_next = '0;
          res_next.status = ST_MATCH;
          res_next.slot_index = 5'(cidx);
          state_next = BK_OUT;
        end else if (chk_v && chk == CntW'(SLOT_COUNT-1)) begin
          state_next = BK_FREE_SCAN;
        end
      end
      BK_FREE_SCAN: begin
        if (chk_v && (!rd_used || cdiff[31])) begin
          do_write = 1'b1;
          res_next = '0;
          res_next.status = ST_ALLOC;
          res_next.slot_index = 5'(cidx);
          state_next = BK_OUT;
        end else if (chk_v && chk == CntW'(SLOT_COUNT-1)) begin
          res_next = '0;
          res_next.status = ST_OVERFLOW;
          state_next = BK_OUT;
        end
      end
      BK_READ: begin
        if (chk_v) begin
          res_next = '0;
          res_next.slot_index = cur.read_slot;
          if (32'(cur.read_slot) >= 32'(SLOT_COUNT)) begin
            res_next.status = ST_DEAD;
          end else begin
            res_next.status = (rd_used && !cdiff[31]) ? ST_LIVE : ST_DEAD;
            res_next.entity = key_v;
            res_next.kind = {1'b0, kind_v} + 3'd1;
            res_next.coords = coords_v;
          end
          state_next = BK_OUT;
        end
      end
      BK_OUT: begin
        if (res_ready) state_next = BK_IDLE;
      end
      default: state_next = BK_IDLE;
    endcase
  end

  assign res_valid = (state == BK_OUT);

  always_ff @(posedge clk) begin
    if (do_write) begin
      slot_key[widx] <= cur.key;
      slot_kind[widx] <= cur.kind2;
      slot_end[widx] <= cur.now_ms + {16'd0, lifetime_ms};
      slot_coords[widx] <= cur.coords;
    end
    if (state == BK_IDLE && q_valid) cur <= q_data;
    res <= res_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
      slot_used <= '0;
      written <= '0;
      scan <= '0;
      chk <= '0;
      chk_v <= 1'b0;
    end else begin
      state <= state_next;
      if (do_write) begin
        slot_used[widx] <= 1'b1;
        written[widx] <= 1'b1;
      end
      chk <= scan;
      chk_v <= 1'b0;
      if (state == BK_IDLE && q_valid) begin
        scan <= (q_data.cmd == CMD_READ) ?
                ((32'(q_data.read_slot) < 32'(SLOT_COUNT)) ? CntW'(q_data.read_slot) : '0)
                : '0;
      end else if (state_next == BK_FREE_SCAN && state == BK_MATCH_SCAN) begin
        scan <= '0;
      end else if ((state == BK_MATCH_SCAN || state == BK_FREE_SCAN || state == BK_READ)
                   && state_next == state) begin
        chk_v <= 1'b1;
        if (!last) scan <= scan + 1'b1;
      end
    end
  end
endmodule
`default_nettype wire

@@ hdl/keyed_expiring_slot_table.sv @@
// ----------------------------------------------------------------------------
// keyed_expiring_slot_table
// timed slot table keyed by entity: match-or-allocate inserts, rail results, slot reads
// ----------------------------------------------------------------------------
// channel      direction  content
// s_axis       in         one insert or read request per transaction
// m_axis       out        one status transaction per request
// apb          in         lifetime_ms register at address 0
// an insert walks the slot memory read port up to twice, one slot a cycle (first for
// its key, then for a free or expired slot); a read reads one slot and a rail none
// a two-entry command queue parts input from the table walk
// rst is synchronous; it clears the valid bits, the queue and lifetime to 200
// the result register holds while m_axis_tready is low
`default_nettype none
module keyed_expiring_slot_table #(
  parameter int SLOT_COUNT = kest_pkg::SlotCountDefault
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic s_axis_tvalid,
  output logic s_axis_tready,
  // operation, beam_kind, entity_key, start_x..z, end_x..z, now_ms, read_slot
  input  wire logic [kest_pkg::InDataW-1:0] s_axis_tdata,
  output logic m_axis_tvalid,
  input  wire logic m_axis_tready,
  // status, slot_index, rail_color, out_entity, out_kind, out_start_x..out_end_z
  output logic [kest_pkg::OutDataW-1:0] m_axis_tdata,
  input  wire logic psel,
  input  wire logic penable,
  input  wire logic pwrite,
  input  wire logic [2:0] paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic pready
);
  import kest_pkg::*;

  logic [15:0] lifetime_ms;
  cmd_t q_data;
  logic q_valid, q_pop, res_valid;
  result_t res;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_LIFETIME) ? {16'd0, lifetime_ms} : '0;

  always_ff @(posedge clk) begin
    if (rst) lifetime_ms <= LifetimeReset;
    else if (psel && penable && pwrite && paddr[2] == REG_LIFETIME)
      lifetime_ms <= pwdata[15:0];
  end

  kest_front u_front (
    .clk, .rst,
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_data(s_axis_tdata),
    .q_data, .q_valid, .q_pop
  );

  kest_back #(.SLOT_COUNT(SLOT_COUNT)) u_back (
    .clk, .rst, .lifetime_ms, .q_data, .q_valid, .q_pop,
    .res, .res_valid, .res_ready(m_axis_tready)
  );

  assign m_axis_tvalid = res_valid;
  assign m_axis_tdata = {res.coords[95:80], res.coords[79:64], res.coords[63:48],
                         res.coords[47:32], res.coords[31:16], res.coords[15:0],
                         res.kind, res.entity, res.rail_color, res.slot_index,
                         res.status};

`ifndef SYNTHESIS
  a_overflow_no_index: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && res.status == ST_OVERFLOW |-> res.slot_index == '0)
    else $error("overflow with slot index");
  a_rail_color: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && res.status != ST_RAIL |-> res.rail_color == '0)
    else $error("stray rail colour");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed under stall");
`endif
endmodule
`default_nettype wire
